// ===== rtl/core/adam_element_update_assert.svh =====
// Assertion macros shared by the adam_element_update RTL.
// Needs a clock named clock and an active-high reset named reset in scope.
`ifndef ADAM_ELEMENT_UPDATE_ASSERT_SVH
`define ADAM_ELEMENT_UPDATE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define AEU_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("adam_element_update: assertion failed");
// next-cycle implication
`define AEU_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("adam_element_update: assertion failed");
`else
`define AEU_ASSERT_IMPLY(lbl, ante, cons)
`define AEU_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/aeu_pkg.sv =====
// Shared types, constants and rounding helpers for adam_element_update.
// No dependencies.
package aeu_pkg;

   localparam int unsigned ROOT_W = 44;   // floor(sqrt(v_hat * 2^40))
   localparam int unsigned VHAT_W = 48;
   localparam int unsigned SREM_W = 46;   // square-root partial remainder
   localparam int unsigned NUM_W  = 80;   // learning_rate * |m_hat|
   localparam int unsigned DEN_W  = 45;   // root + epsilon
   localparam int unsigned QUO_W  = 40;   // update magnitude
   localparam int unsigned SQRT_STAGES = 44;
   localparam int unsigned DIV_STAGES  = 40;

   localparam logic [24:0] ONE_Q24 = 25'h1000000;

   // register map, word index
   typedef enum logic [2:0] {
      REG_BETA_ONE       = 3'd0,
      REG_BETA_TWO       = 3'd1,
      REG_LEARNING_RATE  = 3'd2,
      REG_EPSILON        = 3'd3,
      REG_DECAY_WEIGHT   = 3'd4,
      REG_GRADIENT_SCALE = 3'd5,
      REG_INV_BIAS_ONE   = 3'd6,
      REG_INV_BIAS_TWO   = 3'd7
   } aeu_reg_type;

   // per-word data riding along the root and divide pipelines
   typedef struct packed {
      logic [31:0] param;
      logic [31:0] mom_one;
      logic [31:0] mom_two;
      logic        neg;     // m_hat negative
      logic        skip;    // update dropped
   } aeu_side_type;

   // x / 2^24, to nearest, ties away from zero
   function automatic logic signed [63:0] shr24_rnd(input logic signed [63:0] x);
      logic [63:0] mag;
      logic [63:0] r;
      mag = x[63] ? -x : x;
      r   = (mag + 64'd8388608) >> 24;
      return x[63] ? -$signed(r) : $signed(r);
   endfunction

   // saturate to signed 32 bit
   function automatic logic [31:0] sat_s32(input logic signed [63:0] x);
      logic [31:0] r;
      if (x > 64'sd2147483647) begin
         r = 32'h7FFF_FFFF;
      end else if (x < -64'sd2147483648) begin
         r = 32'h8000_0000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/aeu_sqrt.sv =====
// Pipelined integer square root, one result bit per stage: floor(sqrt(vh*2^40)).
// Uses aeu_pkg; carries the dividend and side data alongside.
module aeu_sqrt (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            in_vld,
   input  logic [aeu_pkg::VHAT_W-1:0]      in_vh,
   input  logic [aeu_pkg::NUM_W-1:0]       in_num,
   input  aeu_pkg::aeu_side_type           in_side,
   output logic                            out_vld,
   output logic [aeu_pkg::ROOT_W-1:0]      out_root,
   output logic [aeu_pkg::NUM_W-1:0]       out_num,
   output aeu_pkg::aeu_side_type           out_side
);

   localparam int unsigned N = aeu_pkg::SQRT_STAGES;

   logic                         vld_ff  [0:N-1];
   logic [aeu_pkg::ROOT_W-1:0]   rt_ff   [0:N-1];
   logic [aeu_pkg::SREM_W-1:0]   rm_ff   [0:N-1];
   logic [aeu_pkg::VHAT_W-1:0]   vh_ff   [0:N-1];
   logic [aeu_pkg::NUM_W-1:0]    num_ff  [0:N-1];
   aeu_pkg::aeu_side_type        side_ff [0:N-1];

   for (genvar k = 0; k < N; k++) begin : g_stage
      localparam int I = N - 1 - k;   // bit pair index of this step

      logic                        vld_src;
      logic [aeu_pkg::ROOT_W-1:0]  rt_src;
      logic [aeu_pkg::SREM_W-1:0]  rm_src;
      logic [aeu_pkg::VHAT_W-1:0]  vh_src;
      logic [aeu_pkg::NUM_W-1:0]   num_src;
      aeu_pkg::aeu_side_type       side_src;
      logic [1:0]                  pair;
      logic [aeu_pkg::SREM_W+1:0]  rm_sh;
      logic [aeu_pkg::SREM_W+1:0]  trial;
      logic [aeu_pkg::ROOT_W-1:0]  rt_in;
      logic [aeu_pkg::SREM_W-1:0]  rm_in;

      if (k == 0) begin : g_first
         assign vld_src  = in_vld;
         assign rt_src   = '0;
         assign rm_src   = '0;
         assign vh_src   = in_vh;
         assign num_src  = in_num;
         assign side_src = in_side;
      end else begin : g_next
         assign vld_src  = vld_ff[k-1];
         assign rt_src   = rt_ff[k-1];
         assign rm_src   = rm_ff[k-1];
         assign vh_src   = vh_ff[k-1];
         assign num_src  = num_ff[k-1];
         assign side_src = side_ff[k-1];
      end

      // the low 40 fraction bits of vh*2^40 are zero
      if (2 * I >= 40) begin : g_pair
         assign pair = vh_src[2*I-39 -: 2];
      end else begin : g_zero
         assign pair = 2'b00;
      end

      // one restoring step
      always_comb begin
         rm_sh = {rm_src, pair};
         trial = {2'b00, rt_src, 2'b01};
         if (rm_sh >= trial) begin
            rm_in = aeu_pkg::SREM_W'(rm_sh - trial);
            rt_in = {rt_src[aeu_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rm_in = rm_sh[aeu_pkg::SREM_W-1:0];
            rt_in = {rt_src[aeu_pkg::ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rt_ff[k]   <= rt_in;
            rm_ff[k]   <= rm_in;
            vh_ff[k]   <= vh_src;
            num_ff[k]  <= num_src;
            side_ff[k] <= side_src;
         end
      end
   end

   assign out_vld  = vld_ff[N-1];
   assign out_root = rt_ff[N-1];
   assign out_num  = num_ff[N-1];
   assign out_side = side_ff[N-1];

endmodule

// ===== rtl/core/aeu_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with overflow check.
// Uses aeu_pkg; quotient is floor(num/den) when it fits in 40 bits.
module aeu_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_vld,
   input  logic [aeu_pkg::NUM_W-1:0]     in_num,
   input  logic [aeu_pkg::DEN_W-1:0]     in_den,
   input  aeu_pkg::aeu_side_type         in_side,
   output logic                          out_vld,
   output logic [aeu_pkg::QUO_W-1:0]     out_quo,
   output aeu_pkg::aeu_side_type         out_side
);

   localparam int unsigned N  = aeu_pkg::DIV_STAGES;
   localparam int unsigned QW = aeu_pkg::QUO_W;
   localparam int unsigned DW = aeu_pkg::DEN_W;

   // index 0 is the entry stage, 1..N the quotient bits
   logic                        vld_ff  [0:N];
   logic [DW-1:0]               rem_ff  [0:N];
   logic [DW-1:0]               den_ff  [0:N];
   logic [QW-1:0]               low_ff  [0:N];
   logic [QW-1:0]               quo_ff  [0:N];
   aeu_pkg::aeu_side_type       side_ff [0:N];

   // entry: quotient reaches 2^40 exactly when num >> 40 >= den
   logic                        over;
   aeu_pkg::aeu_side_type       side_in;

   always_comb begin
      over         = {{(DW-(aeu_pkg::NUM_W-QW)){1'b0}}, in_num[aeu_pkg::NUM_W-1:QW]} >= in_den;
      side_in      = in_side;
      side_in.skip = in_side.skip | over;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= DW'(in_num[aeu_pkg::NUM_W-1:QW]);
         den_ff[0]  <= in_den;
         low_ff[0]  <= in_num[QW-1:0];
         quo_ff[0]  <= '0;
         side_ff[0] <= side_in;
      end
   end

   for (genvar k = 1; k <= N; k++) begin : g_stage
      logic [DW:0]    rs;
      logic [DW-1:0]  rem_in;
      logic [QW-1:0]  quo_in;

      // shift in the next dividend bit, subtract if it fits
      always_comb begin
         rs = {rem_ff[k-1], low_ff[k-1][N-k]};
         if (rs >= {1'b0, den_ff[k-1]}) begin
            rem_in = DW'(rs - {1'b0, den_ff[k-1]});
            quo_in = {quo_ff[k-1][QW-2:0], 1'b1};
         end else begin
            rem_in = rs[DW-1:0];
            quo_in = {quo_ff[k-1][QW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            den_ff[k]  <= den_ff[k-1];
            low_ff[k]  <= low_ff[k-1];
            quo_ff[k]  <= quo_in;
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign out_vld  = vld_ff[N];
   assign out_quo  = quo_ff[N];
   assign out_side = side_ff[N];

endmodule

// ===== rtl/core/adam_element_update.sv =====
// Adam element update: one word (parameter, gradient, both moments) may enter
// every cycle while no result is stalled, and each gives one result word; the
// throughput is one word per cycle, set by the fully pipelined front end (ten
// stages of multiply and round), the 44-stage square root and the 41-stage
// divider. A stalled result freezes the whole pipeline. Registers sit on an APB
// port at byte address 4*i and must be written only while no word is in flight.
// Uses aeu_pkg, aeu_sqrt, aeu_div and adam_element_update_assert.svh.
`include "adam_element_update_assert.svh"

module adam_element_update (
   input  logic         clock,
   input  logic         reset,
   // input words
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,  // param_value, grad_value, moment_one, moment_two
   input  logic         req_tuser,  // grad_bad
   // result words
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [95:0]  rsp_tdata,  // new_param, new_moment_one, new_moment_two
   output logic         rsp_tuser,  // update_skipped
   // register port
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   // ---------------- registers ----------------
   logic [23:0] beta_one_ff, beta_two_ff, decay_weight_ff;
   logic [31:0] learning_rate_ff, epsilon_ff, inv_bias_one_ff, inv_bias_two_ff;
   logic [24:0] gradient_scale_ff;
   aeu_pkg::aeu_reg_type reg_idx;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign reg_idx    = aeu_pkg::aeu_reg_type'(csr_paddr[4:2]);
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         beta_one_ff       <= 24'd15099494;
         beta_two_ff       <= 24'd16760438;
         learning_rate_ff  <= 32'd4294967;
         epsilon_ff        <= 32'd43;
         decay_weight_ff   <= 24'd0;
         gradient_scale_ff <= 25'd16777216;
         inv_bias_one_ff   <= 32'd655360;
         inv_bias_two_ff   <= 32'd65536000;
      end else if (csr_wr) begin
         unique case (reg_idx)
            aeu_pkg::REG_BETA_ONE:       beta_one_ff       <= csr_pwdata[23:0];
            aeu_pkg::REG_BETA_TWO:       beta_two_ff       <= csr_pwdata[23:0];
            aeu_pkg::REG_LEARNING_RATE:  learning_rate_ff  <= csr_pwdata;
            aeu_pkg::REG_EPSILON:        epsilon_ff        <= csr_pwdata;
            aeu_pkg::REG_DECAY_WEIGHT:   decay_weight_ff   <= csr_pwdata[23:0];
            aeu_pkg::REG_GRADIENT_SCALE: gradient_scale_ff <= csr_pwdata[24:0];
            aeu_pkg::REG_INV_BIAS_ONE:   inv_bias_one_ff   <= csr_pwdata;
            aeu_pkg::REG_INV_BIAS_TWO:   inv_bias_two_ff   <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         aeu_pkg::REG_BETA_ONE:       csr_prdata = {8'd0, beta_one_ff};
         aeu_pkg::REG_BETA_TWO:       csr_prdata = {8'd0, beta_two_ff};
         aeu_pkg::REG_LEARNING_RATE:  csr_prdata = learning_rate_ff;
         aeu_pkg::REG_EPSILON:        csr_prdata = epsilon_ff;
         aeu_pkg::REG_DECAY_WEIGHT:   csr_prdata = {8'd0, decay_weight_ff};
         aeu_pkg::REG_GRADIENT_SCALE: csr_prdata = {7'd0, gradient_scale_ff};
         aeu_pkg::REG_INV_BIAS_ONE:   csr_prdata = inv_bias_one_ff;
         aeu_pkg::REG_INV_BIAS_TWO:   csr_prdata = inv_bias_two_ff;
         default:                     csr_prdata = '0;
      endcase
   end

   // ---------------- flow control ----------------
   logic adv;
   logic rsp_vld_ff;

   assign adv        = ~rsp_vld_ff | rsp_tready;
   assign req_tready = adv;

   // ---------------- stage registers ----------------
   logic vld1_ff, vld2_ff, vld3_ff, vld4_ff, vld5_ff;
   logic vld6_ff, vld7_ff, vld8_ff, vld9_ff, vld10_ff, vld11_ff;

   logic [31:0]        p1_ff, p2_ff, p3_ff, p4_ff, p5_ff, p6_ff, p7_ff, p8_ff, p9_ff, p10_ff;
   logic signed [31:0] m1_ff, m2_ff, m3_ff;
   logic [31:0]        v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic               bad1_ff;
   logic signed [57:0] pg1_ff;
   logic signed [56:0] pd1_ff;
   logic signed [31:0] gs2_ff;
   logic signed [32:0] gd2_ff;
   logic signed [31:0] g3_ff;
   logic signed [56:0] b1m4_ff;
   logic signed [57:0] cbg4_ff;
   logic [63:0]        gsq4_ff;
   logic signed [58:0] msum5_ff;
   logic [38:0]        g2_5_ff;
   logic [31:0]        mn6_ff, mn7_ff, mn8_ff, mn9_ff, mn10_ff;
   logic [55:0]        b2v6_ff;
   logic [63:0]        cbg6_ff;
   logic [64:0]        vsum7_ff;
   logic [63:0]        mhp7_ff;
   logic               neg7_ff, neg8_ff, neg9_ff, neg10_ff;
   logic [31:0]        vn8_ff, vn9_ff, vn10_ff;
   logic [47:0]        mh8_ff;
   logic [63:0]        vhp9_ff;
   logic [55:0]        lo9_ff, hi9_ff;
   logic [aeu_pkg::VHAT_W-1:0] vh10_ff;
   logic [aeu_pkg::NUM_W-1:0]  num10_ff;

   // next values
   logic signed [57:0] pg1_in;
   logic signed [56:0] pd1_in;
   logic signed [31:0] gs2_in;
   logic signed [32:0] gd2_in;
   logic signed [63:0] gd2_wide;
   logic signed [31:0] g3_in;
   logic [24:0]        cb1, cb2;
   logic [31:0]        gabs;
   logic signed [56:0] b1m4_in;
   logic signed [57:0] cbg4_in;
   logic [63:0]        gsq4_in;
   logic signed [58:0] msum5_in;
   logic [64:0]        g2_sum;
   logic [31:0]        mn6_in;
   logic [55:0]        b2v6_in;
   logic [63:0]        cbg6_in;
   logic [31:0]        mnabs;
   logic [64:0]        vsum7_in;
   logic [63:0]        mhp7_in;
   logic [65:0]        vn_sum;
   logic [31:0]        vn8_in;
   logic [64:0]        mh_sum;
   logic [47:0]        mh8_in;
   logic [64:0]        vh_sum;
   logic [aeu_pkg::VHAT_W-1:0] vh10_in;
   logic [aeu_pkg::NUM_W-1:0]  num10_in;

   always_comb begin
      // stage 1: gradient scale and decay products
      pg1_in = $signed(req_tdata[63:32]) * $signed({1'b0, gradient_scale_ff});
      pd1_in = $signed(req_tdata[31:0]) * $signed({1'b0, decay_weight_ff});
      // stage 2: round and saturate the scaled gradient (zero if grad_bad), round the decay term
      gs2_in   = bad1_ff ? '0 :
                 aeu_pkg::sat_s32(aeu_pkg::shr24_rnd({{6{pg1_ff[57]}}, pg1_ff}));
      gd2_wide = aeu_pkg::shr24_rnd({{7{pd1_ff[56]}}, pd1_ff});
      gd2_in   = gd2_wide[32:0];
      // stage 3: add decay, saturate
      g3_in = aeu_pkg::sat_s32(64'({{32{gs2_ff[31]}}, gs2_ff}) +
                               64'({{31{gd2_ff[32]}}, gd2_ff}));
      // stage 4: moment products and gradient square
      cb1     = aeu_pkg::ONE_Q24 - {1'b0, beta_one_ff};
      b1m4_in = $signed({1'b0, beta_one_ff}) * m3_ff;
      cbg4_in = $signed({1'b0, cb1}) * g3_ff;
      gabs    = g3_ff[31] ? 32'(-g3_ff) : 32'(g3_ff);
      gsq4_in = gabs * gabs;
      // stage 5: first moment sum, rounded square
      msum5_in = {{2{b1m4_ff[56]}}, b1m4_ff} + {cbg4_ff[57], cbg4_ff};
      g2_sum   = {1'b0, gsq4_ff} + 65'd8388608;
      // stage 6: first moment round/saturate, second moment products
      mn6_in  = aeu_pkg::sat_s32(aeu_pkg::shr24_rnd({{5{msum5_ff[58]}}, msum5_ff}));
      cb2     = aeu_pkg::ONE_Q24 - {1'b0, beta_two_ff};
      b2v6_in = beta_two_ff * v5_ff;
      cbg6_in = cb2 * g2_5_ff;
      // stage 7: second moment sum, m_hat product
      vsum7_in = {9'd0, b2v6_ff} + {1'b0, cbg6_ff};
      mnabs    = mn6_ff[31] ? 32'(-$signed(mn6_ff)) : mn6_ff;
      mhp7_in  = mnabs * inv_bias_one_ff;
      // stage 8: round both, saturate the second moment
      vn_sum = {1'b0, vsum7_ff} + 66'd8388608;
      vn8_in = (vn_sum[65:24] > 42'hFFFF_FFFF) ? 32'hFFFF_FFFF : vn_sum[55:24];
      mh_sum = {1'b0, mhp7_ff} + 65'd32768;
      mh8_in = mh_sum[63:16];
      // stage 10: round v_hat, assemble learning_rate * |m_hat|
      vh_sum   = {1'b0, vhp9_ff} + 65'd32768;
      vh10_in  = vh_sum[63:16];
      num10_in = {24'd0, lo9_ff} + {hi9_ff, 24'd0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff  <= 1'b0;
         vld2_ff  <= 1'b0;
         vld3_ff  <= 1'b0;
         vld4_ff  <= 1'b0;
         vld5_ff  <= 1'b0;
         vld6_ff  <= 1'b0;
         vld7_ff  <= 1'b0;
         vld8_ff  <= 1'b0;
         vld9_ff  <= 1'b0;
         vld10_ff <= 1'b0;
      end else if (adv) begin
         vld1_ff  <= req_tvalid;
         vld2_ff  <= vld1_ff;
         vld3_ff  <= vld2_ff;
         vld4_ff  <= vld3_ff;
         vld5_ff  <= vld4_ff;
         vld6_ff  <= vld5_ff;
         vld7_ff  <= vld6_ff;
         vld8_ff  <= vld7_ff;
         vld9_ff  <= vld8_ff;
         vld10_ff <= vld9_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // stage 1
         p1_ff   <= req_tdata[31:0];
         m1_ff   <= req_tdata[95:64];
         v1_ff   <= req_tdata[127:96];
         bad1_ff <= req_tuser;
         pg1_ff  <= pg1_in;
         pd1_ff  <= pd1_in;
         // stage 2
         p2_ff  <= p1_ff;
         m2_ff  <= m1_ff;
         v2_ff  <= v1_ff;
         gs2_ff <= gs2_in;
         gd2_ff <= gd2_in;
         // stage 3
         p3_ff <= p2_ff;
         m3_ff <= m2_ff;
         v3_ff <= v2_ff;
         g3_ff <= g3_in;
         // stage 4
         p4_ff   <= p3_ff;
         v4_ff   <= v3_ff;
         b1m4_ff <= b1m4_in;
         cbg4_ff <= cbg4_in;
         gsq4_ff <= gsq4_in;
         // stage 5
         p5_ff    <= p4_ff;
         v5_ff    <= v4_ff;
         msum5_ff <= msum5_in;
         g2_5_ff  <= g2_sum[62:24];
         // stage 6
         p6_ff   <= p5_ff;
         mn6_ff  <= mn6_in;
         b2v6_ff <= b2v6_in;
         cbg6_ff <= cbg6_in;
         // stage 7
         p7_ff    <= p6_ff;
         mn7_ff   <= mn6_ff;
         neg7_ff  <= mn6_ff[31];
         vsum7_ff <= vsum7_in;
         mhp7_ff  <= mhp7_in;
         // stage 8
         p8_ff   <= p7_ff;
         mn8_ff  <= mn7_ff;
         neg8_ff <= neg7_ff;
         vn8_ff  <= vn8_in;
         mh8_ff  <= mh8_in;
         // stage 9: v_hat product, learning rate partial products
         p9_ff   <= p8_ff;
         mn9_ff  <= mn8_ff;
         neg9_ff <= neg8_ff;
         vn9_ff  <= vn8_ff;
         vhp9_ff <= vn8_ff * inv_bias_two_ff;
         lo9_ff  <= learning_rate_ff * mh8_ff[23:0];
         hi9_ff  <= learning_rate_ff * mh8_ff[47:24];
         // stage 10
         p10_ff   <= p9_ff;
         mn10_ff  <= mn9_ff;
         neg10_ff <= neg9_ff;
         vn10_ff  <= vn9_ff;
         vh10_ff  <= vh10_in;
         num10_ff <= num10_in;
      end
   end

   // ---------------- square root ----------------
   aeu_pkg::aeu_side_type      side10, sq_side, side11_ff, side11_in;
   logic                       sq_vld;
   logic [aeu_pkg::ROOT_W-1:0] sq_root;
   logic [aeu_pkg::NUM_W-1:0]  sq_num, num11_ff;
   logic [aeu_pkg::DEN_W-1:0]  d11_in, d11_ff;

   always_comb begin
      side10.param   = p10_ff;
      side10.mom_one = mn10_ff;
      side10.mom_two = vn10_ff;
      side10.neg     = neg10_ff;
      side10.skip    = 1'b0;
   end

   aeu_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_vld   (vld10_ff),
      .in_vh    (vh10_ff),
      .in_num   (num10_ff),
      .in_side  (side10),
      .out_vld  (sq_vld),
      .out_root (sq_root),
      .out_num  (sq_num),
      .out_side (sq_side)
   );

   // denominator; zero only with epsilon zero and v_hat zero
   always_comb begin
      d11_in         = {1'b0, sq_root} + {13'd0, epsilon_ff};
      side11_in      = sq_side;
      side11_in.skip = sq_side.skip | (d11_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld11_ff <= 1'b0;
      end else if (adv) begin
         vld11_ff <= sq_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d11_ff    <= d11_in;
         num11_ff  <= sq_num;
         side11_ff <= side11_in;
      end
   end

   // ---------------- divide ----------------
   logic                      dv_vld;
   logic [aeu_pkg::QUO_W-1:0] dv_quo;
   aeu_pkg::aeu_side_type     dv_side;

   aeu_div u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_vld   (vld11_ff),
      .in_num   (num11_ff),
      .in_den   (d11_ff),
      .in_side  (side11_ff),
      .out_vld  (dv_vld),
      .out_quo  (dv_quo),
      .out_side (dv_side)
   );

   // ---------------- apply update, output register ----------------
   logic signed [41:0] p_ext, q_ext, np;
   logic               np_fits, skip_in;
   logic [95:0]        rsp_data_ff;
   logic               rsp_skip_ff;

   always_comb begin
      p_ext   = {{10{dv_side.param[31]}}, dv_side.param};
      q_ext   = {2'b00, dv_quo};
      np      = dv_side.neg ? (p_ext + q_ext) : (p_ext - q_ext);
      np_fits = (np[41:31] == '0) || (np[41:31] == '1);
      skip_in = dv_side.skip | ~np_fits;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         rsp_vld_ff <= dv_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= {dv_side.mom_two, dv_side.mom_one,
                         skip_in ? dv_side.param : np[31:0]};
         rsp_skip_ff <= skip_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_skip_ff;

   // ---------------- checks ----------------
   `AEU_ASSERT_NEXT(a_stall_freezes, !adv, $stable(vld1_ff) && $stable(vld10_ff) && $stable(vld11_ff))
   `AEU_ASSERT_IMPLY(a_den_nonzero, vld11_ff && (epsilon_ff != '0), d11_ff != '0)

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for adam_element_update: streams parameter words through the
// Adam update, predicts each result in a local model and checks it field by field.
// Depends on aeu_pkg and the adam_element_update RTL.
`timescale 1ns / 100ps

module testbench;

   localparam int PIPE_LAT = 97;
   localparam int WATCHDOG = 20000;

   typedef struct packed {
      logic [31:0] param;
      logic [31:0] grad;
      logic        bad;
      logic [31:0] m1;
      logic [31:0] m2;
   } word_type;

   typedef struct packed {
      logic [31:0] param;
      logic [31:0] m1;
      logic [31:0] m2;
      logic        skipped;
   } update_type;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;   // param_value, grad_value, moment_one, moment_two
   logic         req_tuser = 0;    // grad_bad
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [95:0]  rsp_tdata;        // new_param, new_moment_one, new_moment_two
   logic         rsp_tuser;        // update_skipped
   logic         csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [4:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   adam_element_update dut (.*);

   always #10 clock = ~clock;

   // local register copy
   logic [63:0] r_b1, r_b2, r_lr, r_eps, r_wd, r_gs, r_ib1, r_ib2;

   update_type expected_updates[$];
   int      errors = 0;
   int      idle_cycles = 0;
   bit      hold_off = 0;
   bit      rx_random = 1;

   // ---------------- predictor ----------------
   function automatic longint rnd24(longint x);
      longint unsigned m;
      m = x < 0 ? -x : x;
      m = (m + 64'd8388608) >> 24;
      return x < 0 ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint clip32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   function automatic update_type adam_predict(word_type w);
      longint p, g, mn, np;
      longint unsigned v, g2, vn, mh, vh, d, u, rootv, rem;
      logic [127:0] num, q, dd;
      logic [95:0] rad;
      bit skip;
      update_type r;
      p  = longint'($signed(w.param));
      v  = {32'd0, w.m2};
      g  = w.bad ? 0 : clip32(rnd24(longint'($signed(w.grad)) * longint'(r_gs)));
      g  = clip32(g + rnd24(p * longint'(r_wd)));
      mn = clip32(rnd24(longint'(r_b1) * longint'($signed(w.m1))
                        + (longint'(64'd16777216) - longint'(r_b1)) * g));
      g2 = ((g < 0 ? -g : g) * (g < 0 ? -g : g) + 64'd8388608) >> 24;
      vn = (r_b2 * v + (64'd16777216 - r_b2) * g2 + 64'd8388608) >> 24;
      if (vn > 64'hFFFF_FFFF) vn = 64'hFFFF_FFFF;
      mh = ((mn < 0 ? -mn : mn) * r_ib1 + 64'd32768) >> 16;
      vh = (vn * r_ib2 + 64'd32768) >> 16;
      // integer square root of vh * 2^40
      rad = {32'd0, vh} << 40;
      rootv = 0;
      rem = 0;
      for (int i = 47; i >= 0; i--) begin
         rem = (rem << 2) | 64'(rad[2*i +: 2]);
         if (rem >= ((rootv << 2) | 1)) begin
            rem -= (rootv << 2) | 1;
            rootv = (rootv << 1) | 1;
         end else begin
            rootv = rootv << 1;
         end
      end
      d = rootv + r_eps;
      skip = 0;
      np = p;
      if (d == 0) begin
         skip = 1;
      end else begin
         num = 128'(r_lr) * 128'(mh);
         dd = 128'(d);
         q = num / dd;
         if (q >= (128'd1 << 40)) begin
            skip = 1;
         end else begin
            u = q[63:0];
            np = mn < 0 && mh != 0 ? p + longint'(u) : p - longint'(u);
            if (np > 64'sd2147483647 || np < -64'sd2147483648) skip = 1;
         end
      end
      if (skip) np = p;
      r.param = np[31:0];
      r.m1 = mn[31:0];
      r.m2 = vn[31:0];
      r.skipped = skip;
      return r;
   endfunction

   // ---------------- register writes ----------------
   task automatic csr_write(aeu_pkg::aeu_reg_type idx, logic [31:0] val);
      @(posedge clock);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= {idx, 2'b00}; csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      case (idx)
         aeu_pkg::REG_BETA_ONE:       r_b1  = val & 32'hFF_FFFF;
         aeu_pkg::REG_BETA_TWO:       r_b2  = val & 32'hFF_FFFF;
         aeu_pkg::REG_LEARNING_RATE:  r_lr  = val;
         aeu_pkg::REG_EPSILON:        r_eps = val;
         aeu_pkg::REG_DECAY_WEIGHT:   r_wd  = val & 32'hFF_FFFF;
         aeu_pkg::REG_GRADIENT_SCALE: r_gs  = val & 32'h1FF_FFFF;
         aeu_pkg::REG_INV_BIAS_ONE:   r_ib1 = val;
         default:                     r_ib2 = val;
      endcase
   endtask

   task automatic drain;
      while (expected_updates.size() != 0) @(posedge clock);
      repeat (PIPE_LAT + 10) @(posedge clock);
   endtask

   // ---------------- word sender ----------------
   task automatic send_word(word_type w);
      req_tvalid <= 1;
      req_tdata  <= {w.m2, w.m1, w.grad, w.param};
      req_tuser  <= w.bad;
      expected_updates = {expected_updates, adam_predict(w)};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic pause_tx;
      req_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_val;
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return $urandom_range(0, 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
         2: return 32'($signed($urandom_range(0, 33554432)) - 16777216);
         default: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
      endcase
   endfunction

   function automatic word_type rand_word;
      word_type w;
      w.param = rand_val();
      w.grad  = rand_val();
      w.bad   = ($urandom_range(0, 15) == 0);
      w.m1    = rand_val();
      w.m2    = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 1 << 24);
      return w;
   endfunction

   // bursts with gaps
   task automatic send_random(int n);
      int burst;
      burst = 0;
      for (int i = 0; i < n; i++) begin
         if (burst == 0) begin
            burst = $urandom_range(1, 40);
            if ($urandom_range(0, 2) != 0) pause_tx();
         end
         send_word(rand_word());
         burst--;
      end
      req_tvalid <= 0;
   endtask

   // ---------------- test tasks ----------------
   task automatic test_edges;
      word_type w;
      logic [31:0] ext[4] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF};
      for (int i = 0; i < 16; i++) begin
         w.param = ext[i % 4];
         w.grad  = ext[(i / 4) % 4];
         w.bad   = i[0];
         w.m1    = ext[(i + 1) % 4];
         w.m2    = i < 8 ? 32'hFFFF_FFFF : 32'h0;
         send_word(w);
      end
      req_tvalid <= 0;
      drain();
   endtask

   task automatic test_zero_denominator;
      word_type w;
      csr_write(aeu_pkg::REG_EPSILON, 32'd0);
      w = '0;
      send_word(w);
      w.grad = 32'h0100_0000;
      send_word(w);
      w.grad = 32'h0; w.m1 = 32'h8000_0000; w.bad = 1;
      send_word(w);
      req_tvalid <= 0;
      drain();
   endtask

   task automatic test_settings;
      // extremes of each register, then a random mix
      csr_write(aeu_pkg::REG_BETA_ONE, 32'hFF_FFFF);
      csr_write(aeu_pkg::REG_BETA_TWO, 32'd0);
      csr_write(aeu_pkg::REG_LEARNING_RATE, 32'hFFFF_FFFF);
      csr_write(aeu_pkg::REG_EPSILON, 32'd1);
      csr_write(aeu_pkg::REG_DECAY_WEIGHT, 32'hFF_FFFF);
      csr_write(aeu_pkg::REG_GRADIENT_SCALE, 32'h100_0000);
      csr_write(aeu_pkg::REG_INV_BIAS_ONE, 32'hFFFF_FFFF);
      csr_write(aeu_pkg::REG_INV_BIAS_TWO, 32'h1_0000);
      send_random(150);
      drain();
      csr_write(aeu_pkg::REG_BETA_ONE, 32'd0);
      csr_write(aeu_pkg::REG_BETA_TWO, 32'hFF_FFFF);
      csr_write(aeu_pkg::REG_LEARNING_RATE, 32'd0);
      csr_write(aeu_pkg::REG_EPSILON, 32'hFFFF_FFFF);
      csr_write(aeu_pkg::REG_DECAY_WEIGHT, 32'd0);
      csr_write(aeu_pkg::REG_GRADIENT_SCALE, 32'h1FF_FFFF);
      csr_write(aeu_pkg::REG_INV_BIAS_ONE, 32'h1_0000);
      csr_write(aeu_pkg::REG_INV_BIAS_TWO, 32'hFFFF_FFFF);
      send_random(150);
      drain();
      for (int k = 0; k < 4; k++) begin
         csr_write(aeu_pkg::REG_BETA_ONE, $urandom());
         csr_write(aeu_pkg::REG_BETA_TWO, $urandom());
         csr_write(aeu_pkg::REG_LEARNING_RATE, $urandom());
         csr_write(aeu_pkg::REG_EPSILON, $urandom_range(1, 1 << 20));
         csr_write(aeu_pkg::REG_DECAY_WEIGHT, $urandom_range(0, 1) ? $urandom() : 0);
         csr_write(aeu_pkg::REG_GRADIENT_SCALE, $urandom_range(0, 32'h100_0000));
         csr_write(aeu_pkg::REG_INV_BIAS_ONE, $urandom_range(32'h1_0000, 32'h10_0000));
         csr_write(aeu_pkg::REG_INV_BIAS_TWO, $urandom());
         send_random(200);
         drain();
      end
   endtask

   task automatic test_backpressure;
      fork
         begin
            hold_off = 1;
            repeat (400) @(posedge clock);
            hold_off = 0;
         end
         send_random(200);
      join
      drain();
   endtask

   task automatic test_no_stall;
      rx_random = 0;
      send_random(300);
      drain();
      rx_random = 1;
   endtask

   // ---------------- result side ----------------
   always @(posedge clock) begin
      if (reset || hold_off) rsp_tready <= 0;
      else if (!rx_random) rsp_tready <= 1;
      else rsp_tready <= ($urandom_range(0, 9) < 7);
   end

   always @(posedge clock) begin
      update_type exp_u;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_updates.size() == 0) begin
            $display("%0t: unexpected result word %h", $time, rsp_tdata);
            errors++;
         end else begin
            exp_u = expected_updates.pop_front();
            if (rsp_tdata[31:0] !== exp_u.param) begin
               $display("%0t: new_param exp %h got %h", $time, exp_u.param, rsp_tdata[31:0]);
               errors++;
            end
            if (rsp_tdata[63:32] !== exp_u.m1) begin
               $display("%0t: new_moment_one exp %h got %h", $time, exp_u.m1,
                        rsp_tdata[63:32]);
               errors++;
            end
            if (rsp_tdata[95:64] !== exp_u.m2) begin
               $display("%0t: new_moment_two exp %h got %h", $time, exp_u.m2,
                        rsp_tdata[95:64]);
               errors++;
            end
            if (rsp_tuser !== exp_u.skipped) begin
               $display("%0t: update_skipped exp %b got %b", $time, exp_u.skipped, rsp_tuser);
               errors++;
            end
         end
      end
   end

   // watchdog on handshake activity
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      r_b1 = 15099494; r_b2 = 16760438; r_lr = 4294967; r_eps = 43;
      r_wd = 0; r_gs = 16777216; r_ib1 = 655360; r_ib2 = 65536000;
      repeat (4) @(posedge clock);
      reset <= 0;
      test_edges();
      test_zero_denominator();
      test_settings();
      test_backpressure();
      test_no_stall();
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
